// File: hw/rtl/zip_stored_entry_extractor_unit_assert.svh
// Assertion macros used by the checker file of the stored-entry extractor.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ZIP_STORED_ENTRY_EXTRACTOR_UNIT_ASSERT_SVH
`define ZIP_STORED_ENTRY_EXTRACTOR_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define ZSE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A trigger that must be followed by a condition at the next clock edge.
`define ZSE_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: hw/rtl/zip_see_pkg.sv
// Shared types and constants of the stored-entry extractor.
// Used by the top level and by its port checker; depends on nothing.
package zip_see_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_CONTENT = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_STOP    = 2'd3;

    // Stop reasons.
    localparam logic [2:0] REASON_NONE       = 3'd0;
    localparam logic [2:0] REASON_BAD_SIG    = 3'd1;
    localparam logic [2:0] REASON_TOO_BIG    = 3'd2;
    localparam logic [2:0] REASON_COMPRESSED = 3'd3;
    localparam logic [2:0] REASON_EMPTY_NAME = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_TEXT_MODE     = 1'b0;
    localparam logic CFG_MAX_TEXT_SIZE = 1'b1;

    localparam logic        TEXT_MODE_RESET     = 1'b1;
    localparam logic [31:0] MAX_TEXT_SIZE_RESET = 32'd2000000;

    // Header layout.
    localparam logic [4:0] SKIP_LEN   = 5'd14;
    localparam logic [4:0] SIZE_BYTES = 5'd4;
    localparam logic [4:0] LEN_BYTES  = 5'd2;
    localparam logic [4:0] SIG_BYTES  = 5'd4;

    // Text filter byte values.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic [2:0] reason;
        logic       warn;
    } result_t;

    // Local header signature, one byte per position.
    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h50;
            2'd1:    val = 8'h4B;
            2'd2:    val = 8'h03;
            default: val = 8'h04;
        endcase
        return val;
    endfunction

    function automatic result_t make_result(input logic [1:0] kind, input logic [7:0] data,
                                            input logic last, input logic [2:0] reason,
                                            input logic warn);
        result_t r;
        r.kind   = kind;
        r.data   = data;
        r.last   = last;
        r.reason = reason;
        r.warn   = warn;
        return r;
    endfunction

endpackage

// File: hw/rtl/zip_stored_entry_extractor_unit.sv
// Top level of the stored-entry extractor: header parser, text filter and result queue.
// Depends on zip_see_pkg.
//
// The block takes one archive byte per cycle while in_ready is high, and
// updates its header phase and counters in the same cycle, so the input
// side runs at one beat per clock. Results go into a four-entry queue that
// feeds the output port; the input is ready whenever that queue has room for
// two results, because the last name byte of an entry with no extra field and
// no content yields a name result and an entry-end result from one input beat.
// With the output taken every cycle the block sustains one input beat per clock.
module zip_stored_entry_extractor_unit
    import zip_see_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_input,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_kind,
    output logic [7:0]  out_byte,
    output logic        entry_last,
    output logic [2:0]  stop_reason,
    output logic        replaced_warning
);

    localparam logic [3:0] PH_SIG   = 4'd0;
    localparam logic [3:0] PH_SKIP  = 4'd1;
    localparam logic [3:0] PH_SIZE1 = 4'd2;
    localparam logic [3:0] PH_SIZE2 = 4'd3;
    localparam logic [3:0] PH_NLEN  = 4'd4;
    localparam logic [3:0] PH_XLEN  = 4'd5;
    localparam logic [3:0] PH_NAME  = 4'd6;
    localparam logic [3:0] PH_EXTRA = 4'd7;
    localparam logic [3:0] PH_DATA  = 4'd8;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    logic        text_mode_reg;
    logic [31:0] max_text_size_reg;

    logic [3:0]  phase_reg, phase_next;
    logic [4:0]  hidx_reg, hidx_next;
    logic [31:0] entry_size_reg, entry_size_next;
    logic [31:0] second_size_reg, second_size_next;
    logic [15:0] name_length_reg, name_length_next;
    logic [15:0] extra_length_reg, extra_length_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic        nul_seen_reg, nul_seen_next;
    logic        stopped_reg, stopped_next;

    result_t        queue_mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg;

    logic        in_fire, out_fire;
    logic        emit_a, emit_b;
    result_t     res_a, res_b;

    logic        filt_keep, filt_warn, filt_nul;
    logic [7:0]  filt_byte;

    logic [4:0]  hidx_inc;
    logic [31:0] bytes_dec;
    logic [31:0] byte_shifted;
    logic [15:0] len_shifted;
    logic        data_keep, data_warn, data_last;
    logic [7:0]  data_byte;

    assign in_ready = (count_reg <= (QAW + 1)'(QDEPTH - 2));
    assign in_fire  = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign out_fire  = out_valid && out_ready;

    assign out_kind         = queue_mem[rd_ptr_reg].kind;
    assign out_byte         = queue_mem[rd_ptr_reg].data;
    assign entry_last       = queue_mem[rd_ptr_reg].last;
    assign stop_reason      = queue_mem[rd_ptr_reg].reason;
    assign replaced_warning = queue_mem[rd_ptr_reg].warn;

    // Text filter: a NUL hides the rest of the field, CR is dropped, and
    // anything unprintable becomes a flagged space.
    always_comb
    begin
        filt_keep = 1'b0;
        filt_warn = 1'b0;
        filt_nul  = 1'b0;
        filt_byte = in_byte;
        if (nul_seen_reg)
        begin
            filt_keep = 1'b0;
        end
        else if (in_byte == CHAR_NUL)
        begin
            filt_nul = 1'b1;
        end
        else if (in_byte == CHAR_CR)
        begin
            filt_keep = 1'b0;
        end
        else if (in_byte inside {CHAR_TAB, CHAR_LF, CHAR_FF, [CHAR_SPACE:CHAR_TILDE]})
        begin
            filt_keep = 1'b1;
        end
        else
        begin
            filt_keep = 1'b1;
            filt_byte = CHAR_SPACE;
            filt_warn = 1'b1;
        end
    end

    assign hidx_inc     = hidx_reg + 5'd1;
    assign bytes_dec    = bytes_left_reg - 32'd1;
    assign byte_shifted = {24'd0, in_byte} << {hidx_reg[1:0], 3'b000};
    assign len_shifted  = hidx_reg[0] ? {in_byte, 8'd0} : {8'd0, in_byte};

    assign data_keep = text_mode_reg ? filt_keep : 1'b1;
    assign data_byte = text_mode_reg ? filt_byte : in_byte;
    assign data_warn = text_mode_reg ? filt_warn : 1'b0;
    assign data_last = (bytes_dec == 32'd0);

    always_comb
    begin
        phase_next        = phase_reg;
        hidx_next         = hidx_reg;
        entry_size_next   = entry_size_reg;
        second_size_next  = second_size_reg;
        name_length_next  = name_length_reg;
        extra_length_next = extra_length_reg;
        bytes_left_next   = bytes_left_reg;
        nul_seen_next     = nul_seen_reg;
        stopped_next      = stopped_reg;
        emit_a = 1'b0;
        emit_b = 1'b0;
        res_a  = make_result(KIND_STOP, 8'd0, 1'b0, REASON_NONE, 1'b0);
        res_b  = make_result(KIND_END, 8'd0, 1'b1, REASON_NONE, 1'b0);

        if (in_fire && !stopped_reg)
        begin
            if (end_of_input)
            begin
                emit_a       = 1'b1;
                res_a        = make_result(KIND_STOP, 8'd0, 1'b0, REASON_BAD_SIG, 1'b0);
                stopped_next = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_SKIP:
                    begin
                        hidx_next = hidx_inc;
                        if (hidx_inc >= SKIP_LEN)
                        begin
                            phase_next      = PH_SIZE1;
                            hidx_next       = 5'd0;
                            entry_size_next = 32'd0;
                        end
                    end
                    PH_SIZE1:
                    begin
                        entry_size_next = entry_size_reg | byte_shifted;
                        hidx_next       = hidx_inc;
                        if (hidx_inc >= SIZE_BYTES)
                        begin
                            if (text_mode_reg && (entry_size_next > max_text_size_reg))
                            begin
                                emit_a       = 1'b1;
                                res_a        = make_result(KIND_STOP, 8'd0, 1'b0,
                                                           REASON_TOO_BIG, 1'b0);
                                stopped_next = 1'b1;
                            end
                            else
                            begin
                                phase_next       = PH_SIZE2;
                                hidx_next        = 5'd0;
                                second_size_next = 32'd0;
                            end
                        end
                    end
                    PH_SIZE2:
                    begin
                        second_size_next = second_size_reg | byte_shifted;
                        hidx_next        = hidx_inc;
                        if (hidx_inc >= SIZE_BYTES)
                        begin
                            if (second_size_next != entry_size_reg)
                            begin
                                emit_a       = 1'b1;
                                res_a        = make_result(KIND_STOP, 8'd0, 1'b0,
                                                           REASON_COMPRESSED, 1'b0);
                                stopped_next = 1'b1;
                            end
                            else
                            begin
                                phase_next       = PH_NLEN;
                                hidx_next        = 5'd0;
                                name_length_next = 16'd0;
                            end
                        end
                    end
                    PH_NLEN:
                    begin
                        name_length_next = name_length_reg | len_shifted;
                        hidx_next        = hidx_inc;
                        if (hidx_inc >= LEN_BYTES)
                        begin
                            phase_next        = PH_XLEN;
                            hidx_next         = 5'd0;
                            extra_length_next = 16'd0;
                        end
                    end
                    PH_XLEN:
                    begin
                        extra_length_next = extra_length_reg | len_shifted;
                        hidx_next         = hidx_inc;
                        if (hidx_inc >= LEN_BYTES)
                        begin
                            hidx_next = 5'd0;
                            if (name_length_reg == 16'd0)
                            begin
                                emit_a       = 1'b1;
                                res_a        = make_result(KIND_STOP, 8'd0, 1'b0,
                                                           REASON_EMPTY_NAME, 1'b0);
                                stopped_next = 1'b1;
                            end
                            else
                            begin
                                phase_next      = PH_NAME;
                                bytes_left_next = {16'd0, name_length_reg};
                                nul_seen_next   = 1'b0;
                            end
                        end
                    end
                    PH_NAME:
                    begin
                        emit_a = filt_keep;
                        res_a  = make_result(KIND_NAME, filt_byte, 1'b0, REASON_NONE,
                                             filt_warn);
                        if (filt_nul)
                        begin
                            nul_seen_next = 1'b1;
                        end
                        bytes_left_next = bytes_dec;
                        if (data_last)
                        begin
                            if (extra_length_reg != 16'd0)
                            begin
                                phase_next      = PH_EXTRA;
                                bytes_left_next = {16'd0, extra_length_reg};
                            end
                            else if (entry_size_reg != 32'd0)
                            begin
                                phase_next      = PH_DATA;
                                bytes_left_next = entry_size_reg;
                                nul_seen_next   = 1'b0;
                            end
                            else
                            begin
                                // Empty content: the entry end follows the name result.
                                emit_b     = 1'b1;
                                phase_next = PH_SIG;
                                hidx_next  = 5'd0;
                            end
                        end
                    end
                    PH_EXTRA:
                    begin
                        bytes_left_next = bytes_dec;
                        if (data_last)
                        begin
                            if (entry_size_reg != 32'd0)
                            begin
                                phase_next      = PH_DATA;
                                bytes_left_next = entry_size_reg;
                                nul_seen_next   = 1'b0;
                            end
                            else
                            begin
                                emit_a     = 1'b1;
                                res_a      = make_result(KIND_END, 8'd0, 1'b1,
                                                         REASON_NONE, 1'b0);
                                phase_next = PH_SIG;
                                hidx_next  = 5'd0;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        if (text_mode_reg && filt_nul)
                        begin
                            nul_seen_next = 1'b1;
                        end
                        bytes_left_next = bytes_dec;
                        if (data_keep)
                        begin
                            emit_a = 1'b1;
                            res_a  = make_result(KIND_CONTENT, data_byte, data_last,
                                                 REASON_NONE, data_warn);
                        end
                        else if (data_last)
                        begin
                            emit_a = 1'b1;
                            res_a  = make_result(KIND_END, 8'd0, 1'b1, REASON_NONE, 1'b0);
                        end
                        if (data_last)
                        begin
                            phase_next = PH_SIG;
                            hidx_next  = 5'd0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_SIG;
                        if (in_byte != sig_byte(hidx_reg[1:0]))
                        begin
                            emit_a       = 1'b1;
                            res_a        = make_result(KIND_STOP, 8'd0, 1'b0,
                                                       REASON_BAD_SIG, 1'b0);
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            hidx_next = hidx_inc;
                            if (hidx_inc >= SIG_BYTES)
                            begin
                                phase_next = PH_SKIP;
                                hidx_next  = 5'd0;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_mode_reg     <= TEXT_MODE_RESET;
            max_text_size_reg <= MAX_TEXT_SIZE_RESET;
            phase_reg         <= PH_SIG;
            hidx_reg          <= 5'd0;
            entry_size_reg    <= 32'd0;
            second_size_reg   <= 32'd0;
            name_length_reg   <= 16'd0;
            extra_length_reg  <= 16'd0;
            bytes_left_reg    <= 32'd0;
            nul_seen_reg      <= 1'b0;
            stopped_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TEXT_MODE)
                begin
                    text_mode_reg <= cfg_data[0];
                end
                else
                begin
                    max_text_size_reg <= cfg_data;
                end
            end
            phase_reg        <= phase_next;
            hidx_reg         <= hidx_next;
            entry_size_reg   <= entry_size_next;
            second_size_reg  <= second_size_next;
            name_length_reg  <= name_length_next;
            extra_length_reg <= extra_length_next;
            bytes_left_reg   <= bytes_left_next;
            nul_seen_reg     <= nul_seen_next;
            stopped_reg      <= stopped_next;
        end
    end

    // Result queue: up to two writes and one read per cycle.
    always_ff @(posedge clk)
    begin
        if (emit_a)
        begin
            queue_mem[wr_ptr_reg] <= res_a;
        end
        if (emit_a && emit_b)
        begin
            queue_mem[wr_ptr_reg + QAW'(1)] <= res_b;
        end
        else if (emit_b)
        begin
            queue_mem[wr_ptr_reg] <= res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QAW'(emit_a) + QAW'(emit_b);
            if (out_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_reg + (QAW + 1)'(emit_a) + (QAW + 1)'(emit_b)
                         - (QAW + 1)'(out_fire);
        end
    end

endmodule

// File: hw/rtl/zip_see_checker.sv
// Port checker of the stored-entry extractor, attached to the top level by bind.
// Depends on zip_see_pkg and zip_stored_entry_extractor_unit_assert.svh.
`include "zip_stored_entry_extractor_unit_assert.svh"

module zip_see_checker
    import zip_see_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_kind,
    input logic [7:0] out_byte,
    input logic       entry_last,
    input logic [2:0] stop_reason,
    input logic       replaced_warning
);

    // A stalled result beat keeps its payload.
    `ZSE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_byte) && $stable(entry_last) && $stable(stop_reason) && $stable(replaced_warning), "result beat changed while stalled")

    // A stop beat carries a reason and nothing else.
    `ZSE_ASSERT_ALWAYS(a_stop_fields, clk, rst_n, !(out_valid && out_kind == KIND_STOP) || (stop_reason != REASON_NONE && out_byte == 8'd0 && !entry_last && !replaced_warning), "malformed stop beat")

    // Only a stop beat has a reason.
    `ZSE_ASSERT_ALWAYS(a_reason_only_stop, clk, rst_n, !out_valid || out_kind == KIND_STOP || stop_reason == REASON_NONE, "stop reason on a non-stop beat")

    // A replacement warning only comes with a space in a name or content beat.
    `ZSE_ASSERT_ALWAYS(a_warn_space, clk, rst_n, !(out_valid && replaced_warning) || (out_byte == CHAR_SPACE && (out_kind == KIND_NAME || out_kind == KIND_CONTENT)), "warning without a replacement space")

    // Nothing follows a stop beat.
    `ZSE_ASSERT_NEXT(a_stop_final, clk, rst_n, out_valid && out_ready && out_kind == KIND_STOP, !out_valid, "result after a stop")

endmodule

bind zip_stored_entry_extractor_unit zip_see_checker u_zip_see_checker (.*);

// File: verif/zip_stored_entry_extractor_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of zip_stored_entry_extractor_unit: archive streams go in, name,
// content, entry-end and stop beats are predicted by an in-bench scoreboard and compared.
// Depends on zip_see_pkg and the top level of the block only.
module zip_stored_entry_extractor_unit_tb;
    import zip_see_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned TARGET_BEATS = 1450;
    localparam int unsigned QUIET_CYCLES = 16;
    localparam logic [31:0] HEADER_MAGIC  = 32'h04034B50;
    localparam logic [31:0] SIZE_ALL_ONES = 32'hFFFFFFFF;

    typedef enum logic [3:0] {
        PH_SIG,
        PH_SKIP,
        PH_SIZE1,
        PH_SIZE2,
        PH_NLEN,
        PH_XLEN,
        PH_NAME,
        PH_EXTRA,
        PH_DATA
    } parse_phase_t;

    class extract_scoreboard;
        result_t      expected_q[$];
        int unsigned  errors;
        logic         text_mode;
        logic [31:0]  max_text_size;
        parse_phase_t phase;
        logic [4:0]   hdr_idx;
        logic [31:0]  entry_size;
        logic [31:0]  second_size;
        logic [31:0]  bytes_left;
        logic [15:0]  name_len;
        logic [15:0]  extra_len;
        logic         nul_seen;
        logic         halted;

        function new();
            errors        = 0;
            text_mode     = TEXT_MODE_RESET;
            max_text_size = MAX_TEXT_SIZE_RESET;
            phase         = PH_SIG;
            hdr_idx       = '0;
            entry_size    = '0;
            second_size   = '0;
            bytes_left    = '0;
            name_len      = '0;
            extra_len     = '0;
            nul_seen      = 1'b0;
            halted        = 1'b0;
        endfunction

        function void set_register(input logic idx, input logic [31:0] value);
            if (idx == CFG_TEXT_MODE)
                text_mode = value[0];
            else
                max_text_size = value;
        endfunction

        function void add_result(input logic [1:0] kind, input logic [7:0] data,
                                 input logic last, input logic [2:0] reason, input logic warn);
            result_t r;
            r.kind   = kind;
            r.data   = data;
            r.last   = last;
            r.reason = reason;
            r.warn   = warn;
            expected_q.push_back(r);
        endfunction

        function void halt(input logic [2:0] reason);
            add_result(KIND_STOP, 8'h00, 1'b0, reason, 1'b0);
            halted = 1'b1;
        endfunction

        // Returns 1 when the byte survives the text filter.
        function bit text_char(input logic [7:0] b, output logic [7:0] ob, output logic warn);
            warn = 1'b0;
            ob   = 8'h00;
            if (nul_seen)
                return 1'b0;
            if (b == CHAR_NUL)
            begin
                nul_seen = 1'b1;
                return 1'b0;
            end
            if (b == CHAR_CR)
                return 1'b0;
            ob = b;
            if (b == CHAR_TAB || b == CHAR_LF || b == CHAR_FF ||
                (b >= CHAR_SPACE && b <= CHAR_TILDE))
                return 1'b1;
            ob   = CHAR_SPACE;
            warn = 1'b1;
            return 1'b1;
        endfunction

        function void end_of_extra();
            if (entry_size != 0)
            begin
                phase      = PH_DATA;
                bytes_left = entry_size;
                nul_seen   = 1'b0;
            end
            else
            begin
                add_result(KIND_END, 8'h00, 1'b1, REASON_NONE, 1'b0);
                phase   = PH_SIG;
                hdr_idx = '0;
            end
        endfunction

        function void note_beat(input logic [7:0] b, input logic eoi);
            logic [7:0] ob;
            logic       warn;
            logic       kept;
            logic       last;
            logic [4:0] shift;
            shift = {hdr_idx[1:0], 3'b000};
            if (halted)
                return;
            if (eoi)
            begin
                halt(REASON_BAD_SIG);
                return;
            end
            case (phase)
                PH_SKIP:
                begin
                    hdr_idx++;
                    if (hdr_idx >= SKIP_LEN)
                    begin
                        phase      = PH_SIZE1;
                        hdr_idx    = '0;
                        entry_size = '0;
                    end
                end
                PH_SIZE1:
                begin
                    entry_size = entry_size | (32'(b) << shift);
                    hdr_idx++;
                    if (hdr_idx >= SIZE_BYTES)
                    begin
                        if (text_mode && entry_size > max_text_size)
                            halt(REASON_TOO_BIG);
                        else
                        begin
                            phase       = PH_SIZE2;
                            hdr_idx     = '0;
                            second_size = '0;
                        end
                    end
                end
                PH_SIZE2:
                begin
                    second_size = second_size | (32'(b) << shift);
                    hdr_idx++;
                    if (hdr_idx >= SIZE_BYTES)
                    begin
                        if (second_size != entry_size)
                            halt(REASON_COMPRESSED);
                        else
                        begin
                            phase    = PH_NLEN;
                            hdr_idx  = '0;
                            name_len = '0;
                        end
                    end
                end
                PH_NLEN:
                begin
                    name_len = name_len | (16'(b) << {hdr_idx[0], 3'b000});
                    hdr_idx++;
                    if (hdr_idx >= LEN_BYTES)
                    begin
                        phase     = PH_XLEN;
                        hdr_idx   = '0;
                        extra_len = '0;
                    end
                end
                PH_XLEN:
                begin
                    extra_len = extra_len | (16'(b) << {hdr_idx[0], 3'b000});
                    hdr_idx++;
                    if (hdr_idx >= LEN_BYTES)
                    begin
                        hdr_idx = '0;
                        if (name_len == 0)
                            halt(REASON_EMPTY_NAME);
                        else
                        begin
                            phase      = PH_NAME;
                            bytes_left = 32'(name_len);
                            nul_seen   = 1'b0;
                        end
                    end
                end
                PH_NAME:
                begin
                    // Names are filtered whatever the text mode is.
                    if (text_char(b, ob, warn))
                        add_result(KIND_NAME, ob, 1'b0, REASON_NONE, warn);
                    bytes_left--;
                    if (bytes_left == 0)
                    begin
                        if (extra_len != 0)
                        begin
                            phase      = PH_EXTRA;
                            bytes_left = 32'(extra_len);
                        end
                        else
                            end_of_extra();
                    end
                end
                PH_EXTRA:
                begin
                    bytes_left--;
                    if (bytes_left == 0)
                        end_of_extra();
                end
                PH_DATA:
                begin
                    if (text_mode)
                        kept = text_char(b, ob, warn);
                    else
                    begin
                        kept = 1'b1;
                        ob   = b;
                        warn = 1'b0;
                    end
                    bytes_left--;
                    last = (bytes_left == 0);
                    if (kept)
                        add_result(KIND_CONTENT, ob, last, REASON_NONE, warn);
                    else if (last)
                        add_result(KIND_END, 8'h00, 1'b1, REASON_NONE, 1'b0);
                    if (last)
                    begin
                        phase   = PH_SIG;
                        hdr_idx = '0;
                    end
                end
                default:
                begin
                    phase = PH_SIG;
                    if (b != HEADER_MAGIC[shift +: 8])
                        halt(REASON_BAD_SIG);
                    else
                    begin
                        hdr_idx++;
                        if (hdr_idx >= SIG_BYTES)
                        begin
                            phase   = PH_SKIP;
                            hdr_idx = '0;
                        end
                    end
                end
            endcase
        endfunction

        function void compare_field(input string field, input logic [7:0] want,
                                    input logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, actual %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_output(input result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("out_kind: expected no beat, actual %0h (out_byte %0h)",
                       got.kind, got.data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("out_kind", 8'(want.kind), 8'(got.kind));
            compare_field("out_byte", want.data, got.data);
            compare_field("entry_last", 8'(want.last), 8'(got.last));
            compare_field("stop_reason", 8'(want.reason), 8'(got.reason));
            compare_field("replaced_warning", 8'(want.warn), 8'(got.warn));
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_we       = 1'b0;
    logic        cfg_index    = 1'b0;
    logic [31:0] cfg_data     = '0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte      = '0;
    logic        end_of_input = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic        entry_last;
    logic [2:0]  stop_reason;
    logic        replaced_warning;

    extract_scoreboard sb = new();
    bit          input_held = 1'b0;
    bit          no_idle    = 1'b0;
    int unsigned beats_sent  = 0;
    int unsigned cycle_count = 0;
    logic [7:0]  beat_q[$];

    zip_stored_entry_extractor_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_byte          (in_byte),
        .end_of_input     (end_of_input),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_kind         (out_kind),
        .out_byte         (out_byte),
        .entry_last       (entry_last),
        .stop_reason      (stop_reason),
        .replaced_warning (replaced_warning)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Output side: random back-pressure.
    initial
    begin
        int unsigned stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.kind   = out_kind;
            got.data   = out_byte;
            got.last   = entry_last;
            got.reason = stop_reason;
            got.warn   = replaced_warning;
            sb.check_output(got);
        end
    end

    // Valid stays high into the next beat when there is no gap, so it is
    // never lowered and raised within one time step.
    task automatic send_beat(input logic [7:0] b, input logic eoi);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0 && input_held)
        begin
            in_valid   <= 1'b0;
            input_held = 1'b0;
        end
        repeat (gap) @(posedge clk);
        in_valid     <= 1'b1;
        in_byte      <= b;
        end_of_input <= eoi;
        input_held   = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_beat(b, eoi);
        beats_sent++;
    endtask

    task automatic release_input();
        if (input_held)
        begin
            in_valid   <= 1'b0;
            input_held = 1'b0;
        end
    endtask

    task automatic flush_beats();
        while (beat_q.size() != 0)
            send_beat(beat_q.pop_front(), 1'b0);
    endtask

    task automatic wait_drained();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        release_input();
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_register(idx, value);
        cfg_we <= 1'b0;
    endtask

    function automatic void push_le(input logic [31:0] value, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            beat_q.push_back(value[8*i +: 8]);
    endfunction

    function automatic void build_header(input logic [31:0] size1, input logic [31:0] size2,
                                         input logic [15:0] nlen, input logic [15:0] xlen);
        push_le(HEADER_MAGIC, 4);
        repeat (SKIP_LEN) beat_q.push_back(8'($urandom));
        push_le(size1, 4);
        push_le(size2, 4);
        push_le(32'(nlen), 2);
        push_le(32'(xlen), 2);
    endfunction

    function automatic void build_entry(input logic [7:0] name_b[$], input logic [7:0] body_b[$],
                                        input int unsigned xlen);
        build_header(32'(body_b.size()), 32'(body_b.size()), 16'(name_b.size()), 16'(xlen));
        foreach (name_b[i])
            beat_q.push_back(name_b[i]);
        repeat (xlen) beat_q.push_back(8'($urandom));
        foreach (body_b[i])
            beat_q.push_back(body_b[i]);
    endfunction

    // Mostly printable text, with a share of control bytes, NULs and raw bytes.
    function automatic logic [7:0] pick_text_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 8'($urandom_range(CHAR_SPACE, CHAR_TILDE));
        if (r < 54)
            return CHAR_NUL;
        if (r < 66)
        begin
            case ($urandom_range(0, 3))
                0:       return CHAR_TAB;
                1:       return CHAR_LF;
                2:       return CHAR_FF;
                default: return CHAR_CR;
            endcase
        end
        if (r < 70)
            return CHAR_TILDE + 8'd1;
        return 8'($urandom);
    endfunction

    task automatic send_random_entry();
        logic [7:0]  name_b[$];
        logic [7:0]  body_b[$];
        int unsigned nlen;
        int unsigned xlen;
        int unsigned size;
        int unsigned r;
        nlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        xlen = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        r = $urandom_range(0, 99);
        if (r < 25)
            size = 0;
        else if (r < 75)
            size = $urandom_range(1, 12);
        else if (r < 95)
            size = $urandom_range(13, 40);
        else
            size = $urandom_range(41, 120);
        if (sb.text_mode && size > sb.max_text_size)
            size = sb.max_text_size;
        repeat (nlen) name_b.push_back(pick_text_byte());
        repeat (size) body_b.push_back(pick_text_byte());
        build_entry(name_b, body_b, xlen);
        flush_beats();
    endtask

    // Any stop holds until reset, so the stream ends with one stop of a random kind.
    task automatic send_stopping_entry();
        logic [7:0]  name_b[$];
        logic [7:0]  body_b[$];
        logic [31:0] size1;
        logic [31:0] limit;
        int unsigned cut;
        int unsigned k;
        case ($urandom_range(0, 4))
            0:
            begin
                k = $urandom_range(0, 3);
                for (int i = 0; i < k; i++)
                    beat_q.push_back(HEADER_MAGIC[8*i +: 8]);
                beat_q.push_back(HEADER_MAGIC[8*k +: 8] ^ (8'h01 << $urandom_range(0, 7)));
                flush_beats();
            end
            1:
            begin
                name_b = '{8'h61, 8'h62};
                body_b = '{8'h63, 8'h64, 8'h65};
                build_entry(name_b, body_b, 2);
                cut = $urandom_range(0, beat_q.size() - 1);
                while (beat_q.size() > cut)
                    void'(beat_q.pop_back());
                flush_beats();
                send_beat(8'($urandom), 1'b1);
            end
            2:
            begin
                limit = $urandom();
                if (limit == SIZE_ALL_ONES)
                    limit = limit - 1;
                write_register(CFG_TEXT_MODE, 32'd1);
                write_register(CFG_MAX_TEXT_SIZE, limit);
                size1 = limit + 32'd1 + ($urandom() % (SIZE_ALL_ONES - limit));
                build_header(size1, size1, 16'd1, 16'd0);
                flush_beats();
            end
            3:
            begin
                write_register(CFG_MAX_TEXT_SIZE, SIZE_ALL_ONES);
                size1 = $urandom();
                build_header(size1, size1 ^ (32'd1 << $urandom_range(0, 31)), 16'd3, 16'd0);
                flush_beats();
            end
            default:
            begin
                build_header(32'd0, 32'd0, 16'd0, 16'($urandom_range(0, 3)));
                flush_beats();
            end
        endcase
        // These beats must all be ignored.
        send_beat(8'($urandom), 1'b1);
        repeat (7) send_beat(8'($urandom), 1'($urandom_range(0, 1)));
        release_input();
    endtask

    initial
    begin
        logic [7:0]  name_b[$];
        logic [7:0]  body_b[$];
        int unsigned entry_count;
        int unsigned r;
        logic [31:0] limit;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_register(CFG_TEXT_MODE, 32'd1);
        write_register(CFG_MAX_TEXT_SIZE, 32'd5);
        // A NUL cuts the rest of the name; the content is exactly at the size limit.
        name_b = '{8'h41, CHAR_NUL, 8'h42};
        body_b = '{CHAR_TAB, CHAR_LF, CHAR_FF, CHAR_CR, CHAR_TILDE};
        build_entry(name_b, body_b, 2);
        flush_beats();
        // Unprintable name bytes, then no extra field and no content: the last
        // name beat yields both a name beat and an entry-end beat.
        name_b = '{8'h1F, CHAR_TILDE + 8'd1, CHAR_SPACE, 8'hFF};
        body_b = {};
        build_entry(name_b, body_b, 0);
        flush_beats();
        // A NUL hides the last content byte, then a trailing CR does the same.
        name_b = '{8'h78};
        body_b = '{8'h78, CHAR_NUL, 8'h79};
        build_entry(name_b, body_b, 0);
        flush_beats();
        name_b = '{8'h7A};
        body_b = '{8'h61, CHAR_CR};
        build_entry(name_b, body_b, 1);
        flush_beats();

        write_register(CFG_TEXT_MODE, 32'd0);
        name_b = '{CHAR_CR, 8'h6E};
        body_b = '{CHAR_NUL, CHAR_CR, 8'hFF, 8'h80, CHAR_NUL};
        build_entry(name_b, body_b, 0);
        flush_beats();
        // A name of only a NUL and no content: the entry ends on the last extra beat.
        name_b = '{CHAR_NUL};
        body_b = {};
        build_entry(name_b, body_b, 3);
        flush_beats();

        write_register(CFG_MAX_TEXT_SIZE, 32'd0);
        write_register(CFG_TEXT_MODE, 32'd1);
        name_b = '{8'h71};
        body_b = {};
        build_entry(name_b, body_b, 1);
        flush_beats();

        entry_count = 0;
        while (beats_sent < TARGET_BEATS)
        begin
            if ($urandom_range(0, 9) == 0)
                no_idle = !no_idle;
            if (entry_count % 10 == 0)
            begin
                r = $urandom_range(0, 5);
                case (r)
                    0:       limit = 32'd0;
                    1:       limit = SIZE_ALL_ONES;
                    2:       limit = MAX_TEXT_SIZE_RESET;
                    3:       limit = $urandom_range(0, 40);
                    4:       limit = $urandom();
                    default: limit = 32'd1;
                endcase
                write_register(CFG_TEXT_MODE, 32'($urandom_range(0, 1)));
                write_register(CFG_MAX_TEXT_SIZE, limit);
            end
            send_random_entry();
            entry_count++;
        end

        no_idle = 1'b0;
        send_stopping_entry();
        wait_drained();

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/zip_see_pkg.sv
hw/rtl/zip_stored_entry_extractor_unit.sv
hw/rtl/zip_see_checker.sv
verif/zip_stored_entry_extractor_unit_tb.sv
